/* design/falling_sand_grid_step_top_macros.svh */
// assertion macros shared by the falling sand grid step design
// included by modules that carry concurrent checks; depends on nothing else
`ifndef FALLING_SAND_GRID_STEP_TOP_MACROS_SVH
`define FALLING_SAND_GRID_STEP_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FSGS_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FSGS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fsgs_pkg.sv */
// shared types and constants for the falling sand grid step block
// used by fsgs_ctrl, fsgs_dp and falling_sand_grid_step_top; no dependencies
package fsgs_pkg;

    // grid geometry
    localparam int ROWS  = 64;
    localparam int COLS  = 64;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);

    // field widths
    localparam int RC_W   = 6;
    localparam int EL_W   = 20;
    localparam int OP_W   = 2;
    localparam int IN_W   = 2 * RC_W + EL_W;
    localparam int OUT_W  = 8;
    localparam int ACC_W  = 21;
    localparam int PER_W  = 20;
    localparam int LFSR_W = 16;
    localparam int K_W    = 2;

    // widened row and column sums for place range checks
    localparam int ROWX_W = ((ROW_W > RC_W) ? ROW_W : RC_W) + 2;
    localparam int COLX_W = RC_W + 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [ACC_W-1:0]  ACC_MAX      = {ACC_W{1'b1}};
    localparam logic [LFSR_W-1:0] SEED_RESET   = LFSR_W'(44257);
    localparam logic [PER_W-1:0]  PERIOD_RESET = PER_W'(50000);
    localparam logic [K_W-1:0]    PLACE_LAST   = K_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_PLACE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD = 2'd0,
        REG_SEED   = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PL_RD,
        S_PL_WR,
        S_RD_RD,
        S_RD_CAP,
        S_ADV,
        S_G_RD0,
        S_G_RD1,
        S_G_LDB,
        S_G_SCAN,
        S_G_WB,
        S_G_LAST,
        S_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic place_rd;
        logic place_wr;
        logic read_rd;
        logic read_cap;
        logic adv;
        logic gen_rd0;
        logic gen_rd1;
        logic gen_ldb;
        logic gen_scan;
        logic gen_wb;
        logic gen_last;
        logic push;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic k_last;
        logic exceed;
        logic last_col;
        logic last_row;
        logic out_free;
    } sts_t;

endpackage

/* design/fsgs_ctrl.sv */
// sequencer for the falling sand grid step block
// depends on fsgs_pkg for state, command and status types
module fsgs_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [fsgs_pkg::OP_W-1:0] s_tuser,
    input  fsgs_pkg::sts_t            sts,
    output fsgs_pkg::cmd_t            cmd
);

    fsgs_pkg::state_t state_reg;
    fsgs_pkg::state_t state_next;
    fsgs_pkg::op_t    op;

    assign op       = fsgs_pkg::op_t'(s_tuser);
    assign s_tready = (state_reg == fsgs_pkg::S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsgs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            fsgs_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    case (op)
                        fsgs_pkg::OP_PLACE:   state_next = fsgs_pkg::S_PL_RD;
                        fsgs_pkg::OP_ADVANCE: state_next = fsgs_pkg::S_ADV;
                        fsgs_pkg::OP_READ:    state_next = fsgs_pkg::S_RD_RD;
                        default:              state_next = fsgs_pkg::S_DONE;
                    endcase
                end
            end
            fsgs_pkg::S_PL_RD:
            begin
                cmd.place_rd = 1'b1;
                state_next   = fsgs_pkg::S_PL_WR;
            end
            fsgs_pkg::S_PL_WR:
            begin
                cmd.place_wr = 1'b1;
                state_next   = sts.k_last ? fsgs_pkg::S_DONE : fsgs_pkg::S_PL_RD;
            end
            fsgs_pkg::S_RD_RD:
            begin
                cmd.read_rd = 1'b1;
                state_next  = fsgs_pkg::S_RD_CAP;
            end
            fsgs_pkg::S_RD_CAP:
            begin
                cmd.read_cap = 1'b1;
                state_next   = fsgs_pkg::S_DONE;
            end
            fsgs_pkg::S_ADV:
            begin
                cmd.adv    = 1'b1;
                state_next = sts.exceed ? fsgs_pkg::S_G_RD0 : fsgs_pkg::S_DONE;
            end
            fsgs_pkg::S_G_RD0:
            begin
                cmd.gen_rd0 = 1'b1;
                state_next  = fsgs_pkg::S_G_RD1;
            end
            fsgs_pkg::S_G_RD1:
            begin
                cmd.gen_rd1 = 1'b1;
                state_next  = fsgs_pkg::S_G_LDB;
            end
            fsgs_pkg::S_G_LDB:
            begin
                cmd.gen_ldb = 1'b1;
                state_next  = fsgs_pkg::S_G_SCAN;
            end
            fsgs_pkg::S_G_SCAN:
            begin
                cmd.gen_scan = 1'b1;
                if (sts.last_col)
                begin
                    state_next = fsgs_pkg::S_G_WB;
                end
            end
            fsgs_pkg::S_G_WB:
            begin
                cmd.gen_wb = 1'b1;
                state_next = sts.last_row ? fsgs_pkg::S_G_LAST : fsgs_pkg::S_G_SCAN;
            end
            fsgs_pkg::S_G_LAST:
            begin
                cmd.gen_last = 1'b1;
                state_next   = fsgs_pkg::S_DONE;
            end
            fsgs_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = fsgs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fsgs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/fsgs_dp.sv */
// datapath for the falling sand grid step block: grid memory, scan registers,
// lfsr, time accumulator, configuration and output register; depends on fsgs_pkg
`include "falling_sand_grid_step_top_macros.svh"

module fsgs_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  fsgs_pkg::cmd_t                  cmd,
    output fsgs_pkg::sts_t                  sts,
    input  logic [fsgs_pkg::IN_W-1:0]       s_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fsgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsgs_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fsgs_pkg::OUT_W-1:0]      m_tdata
);

    localparam int ROWS   = fsgs_pkg::ROWS;
    localparam int COLS   = fsgs_pkg::COLS;
    localparam int ROW_W  = fsgs_pkg::ROW_W;
    localparam int COL_W  = fsgs_pkg::COL_W;
    localparam int RC_W   = fsgs_pkg::RC_W;
    localparam int EL_W   = fsgs_pkg::EL_W;
    localparam int ACC_W  = fsgs_pkg::ACC_W;
    localparam int PER_W  = fsgs_pkg::PER_W;
    localparam int LFSR_W = fsgs_pkg::LFSR_W;
    localparam int K_W    = fsgs_pkg::K_W;
    localparam int ROWX_W = fsgs_pkg::ROWX_W;
    localparam int COLX_W = fsgs_pkg::COLX_W;
    localparam int OUT_W  = fsgs_pkg::OUT_W;

    // grid memory with per-row valid bits
    logic [COLS-1:0]   mem [ROWS];
    logic [ROWS-1:0]   row_vld_reg;
    logic [COLS-1:0]   rd_data_reg;
    logic              rd_vld_reg;
    logic [COLS-1:0]   rd_row;

    // latched input word
    logic [RC_W-1:0]   row_in_reg;
    logic [RC_W-1:0]   col_in_reg;
    logic [EL_W-1:0]   el_reg;

    // control and configuration state
    logic [ACC_W-1:0]  accum_reg,   accum_next;
    logic [PER_W-1:0]  period_reg,  period_next;
    logic [LFSR_W-1:0] lfsr_reg,    lfsr_next;
    logic [K_W-1:0]    k_reg,       k_next;
    logic [ROW_W-1:0]  gen_row_reg, gen_row_next;
    logic [COL_W-1:0]  col_reg,     col_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // scan payload
    logic [COLS-1:0]   cur_reg,   cur_next;
    logic [COLS-1:0]   below_reg, below_next;
    logic [COLS-1:0]   stay_reg,  stay_next;
    logic [COLS-1:0]   fall_reg,  fall_next;
    logic              res_value_reg, res_value_next;
    logic              res_ran_reg,   res_ran_next;
    logic [OUT_W-1:0]  m_tdata_reg,   m_tdata_next;

    // memory port controls
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    logic [COLS-1:0]   wr_data;

    // helper values
    logic [ROWX_W-1:0] place_rowx;
    logic [COLX_W-1:0] place_colx;
    logic              place_row_ok;
    logic              place_col_ok;
    logic [COLS-1:0]   place_mask;
    logic              read_ok;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;
    logic              exceed;
    logic [ROW_W:0]    gen_row_p2;
    logic [ROW_W:0]    gen_row_p3;
    logic              last_row;
    logic [COL_W-1:0]  col_m1;
    logic [COL_W-1:0]  col_p1;
    logic              not_first;
    logic              not_last;
    logic              left_free;
    logic              right_free;
    logic              lfsr_fb;
    logic              cfg_we;
    logic [LFSR_W-1:0] seed;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // rows never written read as empty
    assign rd_row = rd_vld_reg ? rd_data_reg : '0;

    // place addressing along the diagonal
    assign place_rowx   = ROWX_W'(row_in_reg) + ROWX_W'(k_reg);
    assign place_colx   = COLX_W'(col_in_reg) + COLX_W'(k_reg);
    assign place_row_ok = place_rowx < ROWX_W'(ROWS);
    assign place_col_ok = place_colx < COLX_W'(COLS);
    always_comb
    begin
        place_mask = '0;
        if (place_col_ok)
        begin
            place_mask[place_colx[COL_W-1:0]] = 1'b1;
        end
    end

    assign read_ok = (ROWX_W'(row_in_reg) < ROWX_W'(ROWS))
                   && (COLX_W'(col_in_reg) < COLX_W'(COLS));

    // saturating accumulate and period compare
    assign acc_sum = {1'b0, accum_reg} + (ACC_W + 1)'(el_reg);
    assign acc_sat = acc_sum[ACC_W] ? fsgs_pkg::ACC_MAX : acc_sum[ACC_W-1:0];
    assign exceed  = acc_sat > ACC_W'(period_reg);

    // generation row bookkeeping
    assign gen_row_p2 = (ROW_W + 1)'(gen_row_reg) + (ROW_W + 1)'(2);
    assign gen_row_p3 = (ROW_W + 1)'(gen_row_reg) + (ROW_W + 1)'(3);
    assign last_row   = gen_row_reg == ROW_W'(ROWS - 2);

    // neighbor columns of the scan position
    assign col_m1     = col_reg - COL_W'(1);
    assign col_p1     = col_reg + COL_W'(1);
    assign not_first  = col_reg != '0;
    assign not_last   = col_reg != COL_W'(COLS - 1);
    assign left_free  = not_first && !below_reg[col_m1];
    assign right_free = not_last && !below_reg[col_p1];

    // lfsr taps 16, 14, 13, 11 on a right shift
    assign lfsr_fb = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign seed    = cfg_data[LFSR_W-1:0];

    // status to the sequencer
    assign sts.k_last   = k_reg == fsgs_pkg::PLACE_LAST;
    assign sts.exceed   = exceed;
    assign sts.last_col = !not_last;
    assign sts.last_row = last_row;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    // memory port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.place_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = place_rowx[ROW_W-1:0];
        end
        if (cmd.read_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = ROW_W'(row_in_reg);
        end
        if (cmd.gen_rd0)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        if (cmd.gen_rd1)
        begin
            rd_en   = 1'b1;
            rd_addr = ROW_W'(1);
        end
        if (cmd.gen_ldb)
        begin
            rd_en   = gen_row_p2 < (ROW_W + 1)'(ROWS);
            rd_addr = gen_row_p2[ROW_W-1:0];
        end
        if (cmd.gen_wb)
        begin
            rd_en   = !last_row && (gen_row_p3 < (ROW_W + 1)'(ROWS));
            rd_addr = gen_row_p3[ROW_W-1:0];
            wr_en   = 1'b1;
            wr_addr = gen_row_reg;
            wr_data = stay_reg;
        end
        if (cmd.place_wr)
        begin
            wr_en   = place_row_ok;
            wr_addr = place_rowx[ROW_W-1:0];
            wr_data = rd_row | place_mask;
        end
        if (cmd.gen_last)
        begin
            wr_en   = 1'b1;
            wr_addr = ROW_W'(ROWS - 1);
            wr_data = stay_reg | below_reg;
        end
    end

    // next values for datapath registers
    always_comb
    begin
        accum_next     = accum_reg;
        period_next    = period_reg;
        lfsr_next      = lfsr_reg;
        k_next         = k_reg;
        gen_row_next   = gen_row_reg;
        col_next       = col_reg;
        cur_next       = cur_reg;
        below_next     = below_reg;
        stay_next      = stay_reg;
        fall_next      = fall_reg;
        res_value_next = res_value_reg;
        res_ran_next   = res_ran_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;

        // register writes
        if (cfg_we)
        begin
            case (cfg_index)
                fsgs_pkg::REG_PERIOD:
                begin
                    period_next = cfg_data[PER_W-1:0];
                end
                fsgs_pkg::REG_SEED:
                begin
                    lfsr_next = (seed != '0) ? seed : fsgs_pkg::SEED_RESET;
                end
                default:
                begin
                    period_next = period_reg;
                end
            endcase
        end

        // new item
        if (cmd.load_in)
        begin
            res_value_next = 1'b0;
            res_ran_next   = 1'b0;
            k_next         = '0;
        end

        // diagonal place
        if (cmd.place_wr)
        begin
            k_next = k_reg + K_W'(1);
        end

        // cell read
        if (cmd.read_cap)
        begin
            res_value_next = read_ok & rd_row[col_in_reg[COL_W-1:0]];
        end

        // time advance
        if (cmd.adv)
        begin
            accum_next   = exceed ? '0 : acc_sat;
            res_ran_next = exceed;
        end

        // generation setup
        if (cmd.gen_rd0)
        begin
            gen_row_next = '0;
            col_next     = '0;
            stay_next    = '0;
            fall_next    = '0;
        end
        if (cmd.gen_rd1)
        begin
            cur_next = rd_row;
        end
        if (cmd.gen_ldb)
        begin
            below_next = rd_row;
        end

        // one cell per cycle
        if (cmd.gen_scan)
        begin
            col_next = not_last ? col_p1 : '0;
            if (cur_reg[col_reg])
            begin
                if (!below_reg[col_reg])
                begin
                    fall_next[col_reg] = 1'b1;
                end
                else
                begin
                    lfsr_next = {lfsr_fb, lfsr_reg[LFSR_W-1:1]};
                    if (!lfsr_reg[0] && left_free)
                    begin
                        fall_next[col_m1] = 1'b1;
                    end
                    else if (lfsr_reg[0] && right_free)
                    begin
                        fall_next[col_p1] = 1'b1;
                    end
                    else
                    begin
                        stay_next[col_reg] = 1'b1;
                    end
                end
            end
        end

        // row done: falls become the next row's base
        if (cmd.gen_wb)
        begin
            stay_next = fall_reg;
            fall_next = '0;
            if (!last_row)
            begin
                cur_next     = below_reg;
                below_next   = rd_row;
                gen_row_next = gen_row_reg + ROW_W'(1);
            end
        end

        // result word
        if (cmd.push)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {(OUT_W - 2)'(0), res_ran_reg, res_value_reg};
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg    <= '0;
            period_reg   <= fsgs_pkg::PERIOD_RESET;
            lfsr_reg     <= fsgs_pkg::SEED_RESET;
            k_reg        <= '0;
            gen_row_reg  <= '0;
            col_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            row_vld_reg  <= '0;
        end
        else
        begin
            accum_reg    <= accum_next;
            period_reg   <= period_next;
            lfsr_reg     <= lfsr_next;
            k_reg        <= k_next;
            gen_row_reg  <= gen_row_next;
            col_reg      <= col_next;
            m_tvalid_reg <= m_tvalid_next;
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            row_in_reg <= s_tdata[RC_W-1:0];
            col_in_reg <= s_tdata[2*RC_W-1:RC_W];
            el_reg     <= s_tdata[2*RC_W+EL_W-1:2*RC_W];
        end
        cur_reg       <= cur_next;
        below_reg     <= below_next;
        stay_reg      <= stay_next;
        fall_reg      <= fall_next;
        res_value_reg <= res_value_next;
        res_ran_reg   <= res_ran_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // grid memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= row_vld_reg[rd_addr];
        end
    end

    // checks
    `FSGS_ASSERT_SAME(a_lfsr_nonzero, clk, rst_n, 1'b1, lfsr_reg != '0,
        "lfsr reached the all-zero lockup state")
    `FSGS_ASSERT_NEXT(a_accum_cleared, clk, rst_n, cmd.adv && exceed, accum_reg == '0,
        "accumulator not cleared after a generation was started")
    `FSGS_ASSERT_SAME(a_scan_row_range, clk, rst_n, cmd.gen_scan,
        gen_row_reg <= ROW_W'(ROWS - 2), "scan row past the last movable row")
    `FSGS_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.push,
        !m_tvalid_reg || m_tready, "result pushed over an untaken word")

endmodule

/* design/falling_sand_grid_step_top.sv */
// Each input word is one operation on a 64 by 64 grid of sand cells: place a
// three-cell diagonal, read one cell, or advance time, which runs a generation
// when the accumulated time passes step_period_us. Exactly one result word
// comes back per input word, in order. A generation visits one cell per clock
// and takes at most one lfsr bit per cell; the grid lives in a row memory with
// one write port and one registered read port, updated in place, so every
// operation holds the input side until it finishes.
// The next input word is taken while the previous result still waits on the
// output side. Rows cleared by reset read as empty through per-row valid bits,
// so there is no clearing pass after reset. Configuration writes are always
// taken (cfg_ready is tied high) and must be made while the block is idle;
// register 0 is step_period_us, register 1 is random_seed (zero loads 44257).
// Depends on fsgs_pkg, fsgs_ctrl and fsgs_dp.
module falling_sand_grid_step_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fsgs_pkg::IN_W-1:0]       s_tdata,   // cell_row, cell_col, elapsed_us
    input  logic [fsgs_pkg::OP_W-1:0]       s_tuser,   // op
    // output side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fsgs_pkg::OUT_W-1:0]      m_tdata,   // cell_value, generation_ran, zeros
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fsgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsgs_pkg::CFG_DATA_W-1:0] cfg_data
);

    fsgs_pkg::cmd_t cmd;
    fsgs_pkg::sts_t sts;

    // sequencer
    fsgs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // grid, timing and output datapath
    fsgs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* sim/falling_sand_grid_step_top_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for falling_sand_grid_step_top: place, advance, read and
// unused words plus register writes, every result word predicted from a local grid
// depends on fsgs_pkg and the falling_sand_grid_step_top design files
module falling_sand_grid_step_top_tb;

    localparam int ROWS       = fsgs_pkg::ROWS;
    localparam int COLS       = fsgs_pkg::COLS;
    localparam int IN_W       = fsgs_pkg::IN_W;
    localparam int OP_W       = fsgs_pkg::OP_W;
    localparam int OUT_W      = fsgs_pkg::OUT_W;
    localparam int CFG_IDX_W  = fsgs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = fsgs_pkg::CFG_DATA_W;
    localparam int ACC_W      = fsgs_pkg::ACC_W;
    localparam int LFSR_W     = fsgs_pkg::LFSR_W;
    localparam int PER_W      = fsgs_pkg::PER_W;
    localparam int RC_W       = fsgs_pkg::RC_W;
    localparam int EL_W       = fsgs_pkg::EL_W;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int PLACE_CELLS   = 3;
    localparam int RANDOM_WORDS  = 34;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;
    localparam logic [EL_W-1:0]      EL_FULL    = {EL_W{1'b1}};

    typedef struct packed {
        logic cell_value;
        logic generation_ran;
    } sand_result_t;

    // dut ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow copy of the block state
    logic [COLS-1:0]   sand_grid [ROWS];
    logic [ACC_W-1:0]  accum_us;
    logic [LFSR_W-1:0] draw_lfsr;
    logic [PER_W-1:0]  period_us;

    sand_result_t pending_results [$];
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int words_sent      = 0;
    int words_checked   = 0;
    int mismatch_count  = 0;
    int generations_run = 0;
    int cycle_count     = 0;

    falling_sand_grid_step_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d words still expected",
                     $time, cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one generation: every decision reads the old grid
    task automatic run_sand_generation();
        logic [COLS-1:0] next_rows [ROWS];
        logic            dir_bit;
        for (int r = 0; r < ROWS; r++)
            next_rows[r] = '0;
        for (int r = 0; r + 1 < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                if (sand_grid[r][c])
                begin
                    if (!sand_grid[r+1][c])
                        next_rows[r+1][c] = 1'b1;
                    else
                    begin
                        // blocked below: draw one lfsr bit for the diagonal
                        dir_bit   = draw_lfsr[0];
                        draw_lfsr = {draw_lfsr[0] ^ draw_lfsr[2] ^ draw_lfsr[3] ^ draw_lfsr[5],
                                     draw_lfsr[LFSR_W-1:1]};
                        if (!dir_bit && c > 0 && !sand_grid[r+1][c-1])
                            next_rows[r+1][c-1] = 1'b1;
                        else if (dir_bit && c + 1 < COLS && !sand_grid[r+1][c+1])
                            next_rows[r+1][c+1] = 1'b1;
                        else
                            next_rows[r][c] = 1'b1;
                    end
                end
            end
        end
        // bottom row never moves
        next_rows[ROWS-1] = next_rows[ROWS-1] | sand_grid[ROWS-1];
        for (int r = 0; r < ROWS; r++)
            sand_grid[r] = next_rows[r];
    endtask

    // apply one word to the shadow state and work out its result
    task automatic predict_grid_op(input fsgs_pkg::op_t op, input logic [RC_W-1:0] row,
                                   input logic [RC_W-1:0] col, input logic [EL_W-1:0] el,
                                   output sand_result_t res);
        int sum;
        res = '0;
        case (op)
            fsgs_pkg::OP_PLACE:
            begin
                for (int k = 0; k < PLACE_CELLS; k++)
                    if (int'(row) + k < ROWS && int'(col) + k < COLS)
                        sand_grid[int'(row) + k][int'(col) + k] = 1'b1;
            end
            fsgs_pkg::OP_ADVANCE:
            begin
                sum = int'(accum_us) + int'(el);
                if (sum > int'(fsgs_pkg::ACC_MAX))
                    sum = int'(fsgs_pkg::ACC_MAX);
                accum_us = ACC_W'(sum);
                if (accum_us > period_us)
                begin
                    run_sand_generation();
                    accum_us = '0;
                    res.generation_ran = 1'b1;
                    generations_run++;
                end
            end
            fsgs_pkg::OP_READ:
                res.cell_value = sand_grid[row][col];
            default:
                ;
        endcase
    endtask

    // send one word with random idle gaps before it
    task automatic send_word(input fsgs_pkg::op_t op, input logic [RC_W-1:0] row,
                             input logic [RC_W-1:0] col, input logic [EL_W-1:0] el);
        sand_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {el, col, row};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        predict_grid_op(op, row, col, el, res);
        pending_results.push_back(res);
        words_sent++;
    endtask

    // let every expected word arrive, then a short pause so the block is idle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, mirrored in the shadow state
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            fsgs_pkg::REG_PERIOD: period_us = data[PER_W-1:0];
            fsgs_pkg::REG_SEED:   draw_lfsr = (data[LFSR_W-1:0] != '0) ? data[LFSR_W-1:0]
                                                                       : fsgs_pkg::SEED_RESET;
            default:    ;
        endcase
        @(posedge clk);
    endtask

    // result checker and output backpressure
    always @(posedge clk)
    begin
        sand_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected, actual %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.cell_value)
                begin
                    $display("%0t: cell_value expected %0d actual %0d",
                             $time, want.cell_value, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tdata[1] !== want.generation_ran)
                begin
                    $display("%0t: generation_ran expected %0d actual %0d",
                             $time, want.generation_ran, m_tdata[1]);
                    mismatch_count++;
                end
                if (m_tdata[OUT_W-1:2] !== '0)
                begin
                    $display("%0t: padding expected 0 actual %h", $time, m_tdata[OUT_W-1:2]);
                    mismatch_count++;
                end
                words_checked++;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // grid corners, clipped diagonals, merged grains, unused op
    task automatic test_place_and_read();
        send_word(fsgs_pkg::OP_READ, 0, 0, '0);
        send_word(fsgs_pkg::OP_PLACE, 0, 0, '0);
        send_word(fsgs_pkg::OP_PLACE, 63, 63, EL_FULL);
        send_word(fsgs_pkg::OP_PLACE, 62, 0, '0);
        send_word(fsgs_pkg::OP_PLACE, 0, 62, '0);
        send_word(fsgs_pkg::OP_PLACE, 61, 61, '0);
        send_word(fsgs_pkg::OP_READ, 0, 0, '0);
        send_word(fsgs_pkg::OP_READ, 2, 2, '0);
        send_word(fsgs_pkg::OP_READ, 63, 63, EL_FULL);
        send_word(fsgs_pkg::OP_READ, 63, 1, '0);
        send_word(fsgs_pkg::OP_READ, 1, 63, '0);
        send_word(fsgs_pkg::OP_READ, 0, 63, '0);
        send_word(fsgs_pkg::OP_READ, 62, 62, '0);
        send_word(fsgs_pkg::OP_NOP, 63, 63, EL_FULL);
    endtask

    // accumulator exactly at the period, just past it, and a full-scale step
    task automatic test_advance_threshold();
        send_word(fsgs_pkg::OP_ADVANCE, 0, 0, '0);
        send_word(fsgs_pkg::OP_ADVANCE, 0, 0, EL_W'(fsgs_pkg::PERIOD_RESET));
        send_word(fsgs_pkg::OP_ADVANCE, 0, 0, EL_W'(1));
        send_word(fsgs_pkg::OP_READ, 1, 0, '0);
        send_word(fsgs_pkg::OP_READ, 3, 3, '0);
        send_word(fsgs_pkg::OP_ADVANCE, 63, 63, EL_FULL);
        send_word(fsgs_pkg::OP_READ, 4, 3, '0);
        send_word(fsgs_pkg::OP_READ, 63, 63, '0);
        send_word(fsgs_pkg::OP_READ, 63, 1, '0);
    endtask

    // register extremes: zero period, zero seed, spare indexes, full-scale values
    task automatic test_register_extremes();
        drain_results();
        write_register(fsgs_pkg::REG_PERIOD, '0);
        write_register(fsgs_pkg::REG_SEED, '0);
        send_word(fsgs_pkg::OP_ADVANCE, 0, 0, '0);
        // stacked grains so the lfsr is drawn
        send_word(fsgs_pkg::OP_PLACE, 62, 5, '0);
        send_word(fsgs_pkg::OP_PLACE, 62, 6, '0);
        send_word(fsgs_pkg::OP_PLACE, 61, 6, '0);
        send_word(fsgs_pkg::OP_ADVANCE, 0, 0, EL_W'(1));
        send_word(fsgs_pkg::OP_READ, 62, 6, '0);
        send_word(fsgs_pkg::OP_READ, 63, 5, '0);
        send_word(fsgs_pkg::OP_READ, 62, 7, '0);
        drain_results();
        write_register(fsgs_pkg::REG_SEED, CFG_DATA_W'(1));
        write_register(REG_SPARE2, CFG_DATA_W'($urandom));
        write_register(REG_SPARE3, {CFG_DATA_W{1'b1}});
        write_register(fsgs_pkg::REG_PERIOD, {CFG_DATA_W{1'b1}});
        send_word(fsgs_pkg::OP_PLACE, 60, 6, '0);
        send_word(fsgs_pkg::OP_ADVANCE, 0, 0, EL_FULL);
        send_word(fsgs_pkg::OP_ADVANCE, 0, 0, EL_FULL);
        send_word(fsgs_pkg::OP_READ, 63, 8, '0);
        drain_results();
        write_register(fsgs_pkg::REG_SEED, {CFG_DATA_W{1'b1}});
        write_register(fsgs_pkg::REG_PERIOD, CFG_DATA_W'(1));
        send_word(fsgs_pkg::OP_ADVANCE, 0, 0, EL_W'(2));
        send_word(fsgs_pkg::OP_READ, 63, 7, '0);
    endtask

    // random words, grains mostly near the floor so piles build up
    task automatic test_random_sand(input int idle_pct, input int stall_pct,
                                    input logic [PER_W-1:0] period);
        int              pick;
        logic [RC_W-1:0] row;
        logic [RC_W-1:0] col;
        logic [EL_W-1:0] el;
        drain_results();
        write_register(fsgs_pkg::REG_PERIOD, CFG_DATA_W'(period));
        write_register(fsgs_pkg::REG_SEED, CFG_DATA_W'($urandom));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(99);
            row  = ($urandom_range(3) == 0) ? RC_W'($urandom_range(63))
                                            : RC_W'($urandom_range(63, 44));
            col  = RC_W'($urandom_range(63));
            el   = ($urandom_range(3) == 0) ? EL_W'($urandom)
                                            : EL_W'($urandom_range(int'(period_us) + 200));
            if (pick < 35)
                send_word(fsgs_pkg::OP_PLACE, row, col, el);
            else if (pick < 65)
                send_word(fsgs_pkg::OP_ADVANCE, row, col, el);
            else if (pick < 95)
                send_word(fsgs_pkg::OP_READ, row, col, el);
            else
                send_word(fsgs_pkg::OP_NOP, row, col, el);
        end
    endtask

    // main sequence
    initial
    begin
        int grains;
        for (int r = 0; r < ROWS; r++)
            sand_grid[r] = '0;
        accum_us       = '0;
        draw_lfsr      = fsgs_pkg::SEED_RESET;
        period_us      = fsgs_pkg::PERIOD_RESET;
        send_idle_pct  = 23;
        recv_stall_pct = 53;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_place_and_read();
        test_advance_threshold();
        test_register_extremes();
        test_random_sand(23, 53, PER_W'($urandom_range(2000)));
        test_random_sand(53, 23, '0);
        test_random_sand(0, 0, PER_W'($urandom_range(5000)));
        drain_results();

        grains = 0;
        for (int r = 0; r < ROWS; r++)
            grains += $countones(sand_grid[r]);
        $display("sent %0d words, checked %0d results, %0d generations ran",
                 words_sent, words_checked, generations_run);
        $display("%0d grains left on the grid, %0d mismatches", grains, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
